@@ rtl/swhsd_pkg.sv @@
// Package with the shared codes, widths and reset values of the humidity sensor decoder.
`default_nettype none
package swhsd_pkg;

	localparam int FrameEdgesDefault = 42;
	localparam int EdgeCountW        = 6;
	localparam int FrameBitsW        = 40;

	localparam logic [7:0] ZeroMinReset = 8'd60;
	localparam logic [7:0] ZeroMaxReset = 8'd90;
	localparam logic [7:0] OneMinReset  = 8'd110;
	localparam logic [7:0] OneMaxReset  = 8'd150;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_EDGE    = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_TIMEOUT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_ZERO_MIN = 2'd0,
		REG_ZERO_MAX = 2'd1,
		REG_ONE_MIN  = 2'd2,
		REG_ONE_MAX  = 2'd3
	} reg_idx_t;

endpackage
`default_nettype wire

@@ rtl/single_wire_humidity_sensor_decoder.sv @@
// Top level of the single-wire humidity and temperature sensor frame decoder.
//
// Usage: the input channel carries one operation per transfer (start, line
// edge with its timer value, or timeout). A start arms the decoder. Every edge
// while armed is counted; from edge FirstBitEdge on, the interval to the previous
// edge is classified against the zero and one windows and shifted into a
// 40-bit frame. At the last edge of the frame the checksum is tested and a
// result transfer reports the status with the last checksum-valid humidity and
// temperature words. A timeout while armed reports a short frame instead.
// An input transfer is held in the input register and its result in the
// output register. Throughput: one input transfer per cycle unless stalled;
// the input register feeds the decode logic and the result register in the
// same cycle; state registers update as each item leaves the input register.
// When the receiver stalls, a pending result holds in the output register; the
// input register still drains items that give no result, and stops only when
// it holds an item with a result and the output register is full.
// Reset clears the armed flag, the counters, the stored readings and sets the
// four window registers to their reset values. APB pready is always high;
// users write registers only while the block is idle; it does not check.
`default_nettype none
module single_wire_humidity_sensor_decoder #(
	parameter int FRAME_EDGES = swhsd_pkg::FrameEdgesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] edge_time,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      humidity_raw,
	output logic [15:0]      temperature_raw,
	output logic [5:0]       edges_seen,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CntW = swhsd_pkg::EdgeCountW;
	localparam int FbW  = swhsd_pkg::FrameBitsW;
	localparam logic [CntW-1:0] FrameEdgesW = CntW'(FRAME_EDGES);
	localparam logic [CntW-1:0] FirstBitEdge = CntW'(3);

	// Window registers
	logic [7:0] zero_min_q, zero_max_q, one_min_q, one_max_q;
	logic       cfg_write;

	// Input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] time_s1;

	// Decoder state
	logic            armed_q;
	logic [CntW-1:0] edge_count_q;
	logic [15:0]     prev_time_q;
	logic [FbW-1:0]  frame_q;
	logic [15:0]     good_hum_q, good_temp_q;

	// Output register
	logic        out_valid_s2;
	logic [1:0]  status_s2;
	logic [15:0] hum_s2, temp_s2;
	logic [5:0]  edges_s2;

	// Next-state and result logic
	logic            armed_d;
	logic [CntW-1:0] edge_count_d;
	logic [15:0]     prev_time_d;
	logic [FbW-1:0]  frame_d;
	logic [15:0]     good_hum_d, good_temp_d;
	logic            res_want;
	logic [1:0]      res_status;
	logic [CntW-1:0] cnt_inc;
	logic [15:0]     interval;
	logic [7:0]      interval_sat;
	logic            bit_val;
	logic [FbW-1:0]  frame_shift;
	logic [7:0]      byte_sum;
	logic            s1_go;
	logic            s1_take;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q <= swhsd_pkg::ZeroMinReset;
			zero_max_q <= swhsd_pkg::ZeroMaxReset;
			one_min_q  <= swhsd_pkg::OneMinReset;
			one_max_q  <= swhsd_pkg::OneMaxReset;
		end else if (cfg_write) begin
			case (swhsd_pkg::reg_idx_t'(paddr[3:2]))
				swhsd_pkg::REG_ZERO_MIN: zero_min_q <= pwdata[7:0];
				swhsd_pkg::REG_ZERO_MAX: zero_max_q <= pwdata[7:0];
				swhsd_pkg::REG_ONE_MIN:  one_min_q  <= pwdata[7:0];
				swhsd_pkg::REG_ONE_MAX:  one_max_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (swhsd_pkg::reg_idx_t'(paddr[3:2]))
			swhsd_pkg::REG_ZERO_MIN: prdata = {24'd0, zero_min_q};
			swhsd_pkg::REG_ZERO_MAX: prdata = {24'd0, zero_max_q};
			swhsd_pkg::REG_ONE_MIN:  prdata = {24'd0, one_min_q};
			swhsd_pkg::REG_ONE_MAX:  prdata = {24'd0, one_max_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Bit decision: the interval wraps with the timer and saturates at 255.
	// The zero window takes priority; an interval in neither window reads as 0.
	assign cnt_inc      = edge_count_q + CntW'(1);
	assign interval     = time_s1 - prev_time_q;
	assign interval_sat = (|interval[15:8]) ? 8'hFF : interval[7:0];
	always_comb begin
		if (interval_sat > zero_min_q && interval_sat < zero_max_q) begin
			bit_val = 1'b0;
		end else if (interval_sat > one_min_q && interval_sat < one_max_q) begin
			bit_val = 1'b1;
		end else begin
			bit_val = 1'b0;
		end
	end

	assign frame_shift = (cnt_inc >= FirstBitEdge) ? {frame_q[FbW-2:0], bit_val} : frame_q;
	assign byte_sum    = frame_shift[39:32] + frame_shift[31:24]
		+ frame_shift[23:16] + frame_shift[15:8];

	always_comb begin
		armed_d      = armed_q;
		edge_count_d = edge_count_q;
		prev_time_d  = prev_time_q;
		frame_d      = frame_q;
		good_hum_d   = good_hum_q;
		good_temp_d  = good_temp_q;
		res_want     = 1'b0;
		res_status   = swhsd_pkg::ST_OK;
		case (swhsd_pkg::op_t'(op_s1))
			swhsd_pkg::OP_START: begin
				armed_d      = 1'b1;
				edge_count_d = '0;
				frame_d      = '0;
			end
			swhsd_pkg::OP_TIMEOUT: begin
				if (armed_q) begin
					armed_d    = 1'b0;
					res_want   = 1'b1;
					res_status = swhsd_pkg::ST_TIMEOUT;
				end
			end
			swhsd_pkg::OP_EDGE: begin
				if (armed_q) begin
					edge_count_d = cnt_inc;
					prev_time_d  = time_s1;
					frame_d      = frame_shift;
					if (cnt_inc == FrameEdgesW) begin
						armed_d  = 1'b0;
						res_want = 1'b1;
						if (byte_sum == frame_shift[7:0]) begin
							res_status  = swhsd_pkg::ST_OK;
							good_hum_d  = frame_shift[39:24];
							good_temp_d = frame_shift[23:8];
						end else begin
							res_status = swhsd_pkg::ST_CHECKSUM;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// The item in the input register leaves unless it has a result and the
	// output register is full and stalled.
	assign s1_go    = !res_want || !out_valid_s2 || out_ready;
	assign s1_take  = valid_s1 && s1_go;
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= operation;
			time_s1 <= edge_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			edge_count_q <= '0;
			prev_time_q  <= '0;
			frame_q      <= '0;
			good_hum_q   <= '0;
			good_temp_q  <= '0;
		end else if (s1_take) begin
			armed_q      <= armed_d;
			edge_count_q <= edge_count_d;
			prev_time_q  <= prev_time_d;
			frame_q      <= frame_d;
			good_hum_q   <= good_hum_d;
			good_temp_q  <= good_temp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_take && res_want) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && res_want) begin
			status_s2 <= res_status;
			hum_s2    <= good_hum_d;
			temp_s2   <= good_temp_d;
			edges_s2  <= edge_count_d;
		end
	end

	assign out_valid       = out_valid_s2;
	assign status          = status_s2;
	assign humidity_raw    = hum_s2;
	assign temperature_raw = temp_s2;
	assign edges_seen      = edges_s2;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= FrameEdgesW)
		else $error("edge count passed the frame length");

	a_disarm_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(armed_q) |-> out_valid_s2)
		else $error("decoder disarmed without loading a result");

	a_full_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && (status_s2 == swhsd_pkg::ST_OK || status_s2 == swhsd_pkg::ST_CHECKSUM)
		|-> edges_s2 == FrameEdgesW)
		else $error("frame result reported with a short edge count");

	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && status_s2 == swhsd_pkg::ST_TIMEOUT |-> edges_s2 < FrameEdgesW)
		else $error("timeout reported with a complete edge count");
`endif

endmodule
`default_nettype wire
